// ===== rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, register codes and controller/datapath interface types
// for the set associative cache tag lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // default geometry
  localparam int unsigned DefAddrBits     = 10;
  localparam int unsigned DefMaxWays      = 4;
  localparam int unsigned DefMaxIndexBits = 8;

  // configuration register widths
  localparam int unsigned IobCfgW  = 4;
  localparam int unsigned ObCfgW   = 2;
  localparam int unsigned WaysCfgW = 3;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned CfgIdxW  = 2;

  // configuration reset values
  localparam logic [IobCfgW-1:0]  IobReset  = IobCfgW'(5);
  localparam logic [ObCfgW-1:0]   ObReset   = ObCfgW'(2);
  localparam logic [WaysCfgW-1:0] WaysReset = WaysCfgW'(1);

  localparam int unsigned CountW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INDEX_AND_OFFSET_BITS = 2'd0,
    REG_OFFSET_BITS           = 2'd1,
    REG_WAYS_IN_USE           = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic clear_step;  // clear one row of valid bits
    logic capture;     // take a request and read its set
    logic commit;      // resolve lookup, update set, load result
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;  // clearing the last row
    logic out_stall;   // result register still held by the consumer
  } ctrl_status_t;

endpackage

// ===== rtl/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Controller: clears the valid bits after reset, then sequences each request
// through set read and lookup/update.
// ----------------------------------------------------------------------------
module sacl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sacl_pkg::ctrl_status_t status_i,
  output sacl_pkg::ctrl_cmd_t    cmd_o
);
  import sacl_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!status_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    in_ready_d = (state_d == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      in_ready_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_q <= in_ready_d;
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// ===== rtl/sacl_datapath.sv =====
// ----------------------------------------------------------------------------
// sacl_datapath
// Configuration registers, address split, tag and valid memories, way
// compare and replacement choice, counters and the result register.
// ----------------------------------------------------------------------------
module sacl_datapath #(
  parameter int unsigned ADDR_BITS      = sacl_pkg::DefAddrBits,
  parameter int unsigned MAX_WAYS       = sacl_pkg::DefMaxWays,
  parameter int unsigned MAX_INDEX_BITS = sacl_pkg::DefMaxIndexBits,
  localparam int unsigned WayW          = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sacl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sacl_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [ADDR_BITS-1:0]            address_i,
  input  sacl_pkg::ctrl_cmd_t             cmd_i,
  output sacl_pkg::ctrl_status_t          status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            hit_o,
  output logic [WayW-1:0]                 way_o,
  output logic [sacl_pkg::CountW-1:0]     hit_count_o,
  output logic [sacl_pkg::CountW-1:0]     miss_count_o
);
  import sacl_pkg::*;

  localparam int unsigned TagW    = ADDR_BITS - 1;
  localparam int unsigned SetW    = MAX_INDEX_BITS;
  localparam int unsigned NumSets = 1 << MAX_INDEX_BITS;
  localparam int unsigned IobW    = $clog2(MAX_INDEX_BITS + 1);
  localparam int unsigned WcntW   = $clog2(MAX_WAYS + 1);
  localparam int unsigned XW      = ADDR_BITS + MAX_INDEX_BITS;

  // configuration
  logic [IobCfgW-1:0]  iob_cfg_q;
  logic [ObCfgW-1:0]   ob_cfg_q;
  logic [WaysCfgW-1:0] ways_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iob_cfg_q  <= IobReset;
      ob_cfg_q   <= ObReset;
      ways_cfg_q <= WaysReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_INDEX_AND_OFFSET_BITS: iob_cfg_q  <= cfg_data_i[IobCfgW-1:0];
        REG_OFFSET_BITS:           ob_cfg_q   <= cfg_data_i[ObCfgW-1:0];
        REG_WAYS_IN_USE:           ways_cfg_q <= cfg_data_i[WaysCfgW-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [IobW-1:0]  iob_eff, ob_eff;
  logic [WcntW-1:0] ways_eff;

  always_comb begin
    if (iob_cfg_q == '0)                 iob_eff = IobW'(1);
    else if (iob_cfg_q > MAX_INDEX_BITS) iob_eff = IobW'(MAX_INDEX_BITS);
    else                                 iob_eff = IobW'(iob_cfg_q);
    if (IobW'(ob_cfg_q) > iob_eff || ob_cfg_q > MAX_INDEX_BITS) ob_eff = iob_eff;
    else                                                        ob_eff = IobW'(ob_cfg_q);
    if (ways_cfg_q == '0)          ways_eff = WcntW'(1);
    else if (ways_cfg_q > MAX_WAYS) ways_eff = WcntW'(MAX_WAYS);
    else                           ways_eff = WcntW'(ways_cfg_q);
  end

  // address split
  logic [XW-1:0]   addr_x;
  logic [SetW-1:0] set_mask, set_d;
  logic [TagW-1:0] tag_d;

  always_comb begin
    addr_x   = XW'(address_i);
    set_mask = ~({SetW{1'b1}} << (iob_eff - ob_eff));
    set_d    = SetW'(addr_x >> ob_eff) & set_mask;
    tag_d    = TagW'(address_i >> iob_eff);
  end

  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  // memories, one row per set
  logic [MAX_WAYS-1:0][TagW-1:0] tag_mem [NumSets];
  logic [MAX_WAYS-1:0]           vld_mem [NumSets];
  logic [MAX_WAYS-1:0][TagW-1:0] tag_rd_q, tag_wr;
  logic [MAX_WAYS-1:0]           vld_rd_q, vld_wr;
  logic [SetW-1:0]               clr_cnt_q;
  logic                          hit;
  logic [WayW-1:0]               chosen;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) tag_rd_q <= tag_mem[set_d];
    if (cmd_i.commit && !hit) tag_mem[set_q] <= tag_wr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) vld_rd_q <= vld_mem[set_d];
    if (cmd_i.clear_step)  vld_mem[clr_cnt_q] <= '0;
    else if (cmd_i.commit) vld_mem[set_q]     <= vld_wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              clr_cnt_q <= '0;
    else if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  // way compare and replacement
  logic            free;
  logic [WayW-1:0] hit_way, free_way;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    // scan high to low so the lowest way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WcntW'(w) < ways_eff) begin
        if (vld_rd_q[w] && (tag_rd_q[w] == tag_q)) begin
          hit     = 1'b1;
          hit_way = WayW'(w);
        end
        if (!vld_rd_q[w]) begin
          free     = 1'b1;
          free_way = WayW'(w);
        end
      end
    end
    if (hit)       chosen = hit_way;
    else if (free) chosen = free_way;
    else           chosen = WayW'(ways_eff - 1'b1);
    tag_wr         = tag_rd_q;
    tag_wr[chosen] = tag_q;
    vld_wr         = vld_rd_q;
    vld_wr[chosen] = 1'b1;
  end

  // counters and result register
  logic              out_valid_q;
  logic              hit_q;
  logic [WayW-1:0]   way_q;
  logic [CountW-1:0] hits_q, misses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
      if (hit && hits_q != '1)      hits_q   <= hits_q + 1'b1;
      if (!hit && misses_q != '1)   misses_q <= misses_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q <= hit;
      way_q <= chosen;
    end
  end

  assign status_o.clear_last = (clr_cnt_q == '1);
  assign status_o.out_stall  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign way_o        = way_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

endmodule

// ===== rtl/set_assoc_cache_tag_lookup.sv =====
// Set associative cache tag lookup. Each request carries a word address that
// is split into tag, set index and word offset under the configured widths;
// the ways in use of the set are compared, a hit reports the lowest matching
// way, and a miss fills the lowest invalid way or else the last way in use.
// On each request the set's tag and valid row are first read from the
// single-port memories into registers; the row is then compared, written
// back and the result register loaded. A new request is taken only after
// the write-back, so one request is in flight at a time; a held result
// delays the write-back until it is taken. After reset the valid bits are
// cleared one set per cycle, all 2**MAX_INDEX_BITS sets, while no request
// is taken; configuration writes are accepted throughout. Hit and miss
// counters saturate at all ones.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Top level: controller and datapath of the tag lookup.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup #(
  parameter int unsigned ADDR_BITS      = sacl_pkg::DefAddrBits,
  parameter int unsigned MAX_WAYS       = sacl_pkg::DefMaxWays,
  parameter int unsigned MAX_INDEX_BITS = sacl_pkg::DefMaxIndexBits,
  localparam int unsigned WayW          = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sacl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sacl_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ADDR_BITS-1:0]          address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [WayW-1:0]               way_o,
  output logic [sacl_pkg::CountW-1:0]   hit_count_o,
  output logic [sacl_pkg::CountW-1:0]   miss_count_o
);
  import sacl_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sacl_datapath #(
    .ADDR_BITS      (ADDR_BITS),
    .MAX_WAYS       (MAX_WAYS),
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .address_i    (address_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .hit_o        (hit_o),
    .way_o        (way_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o)
  );

endmodule

// ===== rtl/sacl_checker.sv =====
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the tag lookup, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_checker #(
  parameter int unsigned ADDR_BITS      = sacl_pkg::DefAddrBits,
  parameter int unsigned MAX_WAYS       = sacl_pkg::DefMaxWays,
  localparam int unsigned WayW          = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [ADDR_BITS-1:0]        address_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        hit_o,
  input logic [WayW-1:0]             way_o,
  input logic [sacl_pkg::CountW-1:0] hit_count_o,
  input logic [sacl_pkg::CountW-1:0] miss_count_o
);
  import sacl_pkg::*;

  // a waiting request keeps its address
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(address_i))
    else $error("request changed while waiting");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(way_o)
      && $stable(hit_count_o) && $stable(miss_count_o))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> hit_count_o != '0)
    else $error("hit reported with zero hit count");

  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> miss_count_o != '0)
    else $error("miss reported with zero miss count");

endmodule

bind set_assoc_cache_tag_lookup sacl_checker #(
  .ADDR_BITS (ADDR_BITS),
  .MAX_WAYS  (MAX_WAYS)
) u_sacl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .address_i    (address_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hit_o        (hit_o),
  .way_o        (way_o),
  .hit_count_o  (hit_count_o),
  .miss_count_o (miss_count_o)
);
